// ===== sv/csrvd_pkg.sv =====
// Shared types and constants for the CSR vertex deletion / max degree unit.
// No dependencies.
package csrvd_pkg;

	localparam int MAX_VERTICES_DEF = 1024;
	localparam int ADJ_DEPTH_DEF    = 8192;

	localparam int CMD_W    = 2;
	localparam int VTX_W    = 10;
	localparam int OFF_W    = 13;
	localparam int DEG_W    = 10;
	localparam int CFG_W    = 11;

	localparam logic [CFG_W-1:0] VCOUNT_RESET = 11'd1024;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD_VERTEX = 2'd0,
		CMD_LOAD_ADJ    = 2'd1,
		CMD_DELETE      = 2'd2,
		CMD_FIND        = 2'd3
	} cmd_t;

	typedef enum logic {
		ST_OK  = 1'b0,
		ST_BAD = 1'b1
	} status_t;

endpackage

// ===== sv/csr_vertex_delete_max_degree_unit.sv =====
// CSR graph store with vertex deletion and a maximum-degree search; one command in flight.
// Loads complete from idle. Find reads each vertex word in the effective count, one read a cycle.
// Delete reads the vertex, then scans each live neighbor's list and writes back its word;
// skipped neighbors are passed over, and a deleted vertex or a list past the store ends it at once.
// A result waiting in the output register holds the input. After arst_n drops, a clearing pass
// zeroes all MAX_VERTICES vertex memory words; in_stall stays high during it. Uses csrvd_pkg.
module csr_vertex_delete_max_degree_unit
	import csrvd_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int ADJ_DEPTH    = ADJ_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	// configuration write channel
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data,
	// command channel
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [CMD_W-1:0] command,
	input  logic [VTX_W-1:0] vertex,
	input  logic [OFF_W-1:0] start_offset,
	input  logic [DEG_W-1:0] initial_degree,
	input  logic [OFF_W-1:0] adj_index,
	input  logic [VTX_W-1:0] neighbor,
	// result channel
	output logic             out_valid,
	input  logic             out_stall,
	output logic [VTX_W-1:0] max_vertex,
	output logic             status
);

	// index widths follow the store depths
	localparam int VW  = $clog2(MAX_VERTICES);
	localparam int AW  = $clog2(ADJ_DEPTH);
	// vertex counter width: holds MAX_VERTICES and the 11-bit register
	localparam int KW  = (VW + 1 > CFG_W) ? VW + 1 : CFG_W;
	// adjacency position width: holds ADJ_DEPTH and offset + degree
	localparam int CW  = (AW + 1 > OFF_W + 1) ? AW + 1 : OFF_W + 1;
	// vertex memory word: {deleted, offset, degree}
	localparam int VMW = 1 + OFF_W + DEG_W;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_FIND,
		S_DEL_CHK,
		S_WALK,
		S_WALK_NB,
		S_NB_CHK,
		S_NB_LAST,
		S_SCAN,
		S_NB_WB
	} state_t;

	state_t state_q;

	// memories: vertex table and adjacency store, registered read
	logic [VMW-1:0]   vmem [MAX_VERTICES];
	logic [VTX_W-1:0] amem [ADJ_DEPTH];

	logic [VMW-1:0]   vrd_q;
	logic [VTX_W-1:0] ard_q;

	logic             vwe, awe;
	logic [VW-1:0]    vaddr, vwaddr;
	logic [VMW-1:0]   vwdata;
	logic [AW-1:0]    aaddr, awaddr;
	logic [VTX_W-1:0] awdata;

	// control and payload registers
	logic [CFG_W-1:0] vcount_q;
	logic [VW-1:0]    clr_q;
	logic [VW-1:0]    v_q;
	logic [OFF_W-1:0] voff_q;
	logic [DEG_W-1:0] vdeg_q;
	logic [CW-1:0]    i_q;
	logic             bad_q;
	logic [VW-1:0]    nb_q;
	logic [OFF_W-1:0] noff_q;
	logic [DEG_W-1:0] ndeg_q;
	logic [CW-1:0]    j_q;
	logic [CW-1:0]    last_q;
	logic [VTX_W-1:0] lastval_q;
	logic             sc_s1;
	logic [AW-1:0]    sa_s1;
	logic [KW-1:0]    f_q;
	logic             fv_s1;
	logic [VW-1:0]    fa_s1;
	logic [VW-1:0]    best_q;
	logic [DEG_W-1:0] bdeg_q;
	logic             out_valid_q;
	logic [VTX_W-1:0] max_vertex_q;
	logic             status_q;

	// decoded conditions
	logic             acc, take;
	logic [KW-1:0]    cnt_k, vert_k;
	logic             vok, aok;
	logic [VW-1:0]    vidx;
	logic [CW-1:0]    adj_c;
	logic             rd_del;
	logic [OFF_W-1:0] rd_off;
	logic [DEG_W-1:0] rd_deg;
	logic [CW-1:0]    rd_end, rd_last, walk_end;
	logic             rd_end_bad, walk_more, nb_bad, f_more, j_more, hit;

	assign cfg_ready  = 1'b1;
	assign out_valid  = out_valid_q;
	assign max_vertex = max_vertex_q;
	assign status     = status_q;

	// accept only when idle and the output register is free or draining
	assign in_stall = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign acc      = in_valid && !in_stall;
	assign take     = out_valid_q && !out_stall;

	// effective vertex count saturates at the store depth
	assign cnt_k  = (KW'(vcount_q) > KW'(MAX_VERTICES)) ? KW'(MAX_VERTICES) : KW'(vcount_q);
	assign vert_k = KW'(vertex);
	assign vok    = vert_k < cnt_k;
	assign vidx   = vert_k[VW-1:0];
	assign adj_c  = CW'(adj_index);
	assign aok    = adj_c < CW'(ADJ_DEPTH);

	assign rd_del     = vrd_q[VMW-1];
	assign rd_off     = vrd_q[OFF_W+DEG_W-1:DEG_W];
	assign rd_deg     = vrd_q[DEG_W-1:0];
	assign rd_end     = CW'(rd_off) + CW'(rd_deg);
	assign rd_last    = rd_end - CW'(1);
	assign rd_end_bad = rd_end > CW'(ADJ_DEPTH);
	assign walk_end   = CW'(voff_q) + CW'(vdeg_q);
	assign walk_more  = i_q < walk_end;
	assign nb_bad     = KW'(ard_q) >= cnt_k;
	assign f_more     = f_q < cnt_k;
	assign j_more     = j_q < last_q;
	assign hit        = sc_s1 && (KW'(ard_q) == KW'(v_q));

	// memory port control
	always_comb begin
		vwe    = 1'b0;
		vwaddr = v_q;
		vwdata = {1'b1, voff_q, vdeg_q};
		vaddr  = v_q;
		awe    = 1'b0;
		awaddr = sa_s1;
		awdata = lastval_q;
		aaddr  = i_q[AW-1:0];
		case (state_q)
			S_CLEAR: begin
				vwe    = 1'b1;
				vwaddr = clr_q;
				vwdata = '0;
			end
			S_IDLE: begin
				vaddr = vidx;
				if (acc && command == CMD_LOAD_VERTEX && vok) begin
					vwe    = 1'b1;
					vwaddr = vidx;
					vwdata = {1'b0, start_offset, initial_degree};
				end
				if (acc && command == CMD_LOAD_ADJ && aok) begin
					awe    = 1'b1;
					awaddr = adj_c[AW-1:0];
					awdata = neighbor;
				end
			end
			S_FIND: vaddr = f_q[VW-1:0];
			S_WALK: begin
				// finish: mark the deleted vertex with its current degree
				if (!walk_more) vwe = 1'b1;
			end
			S_WALK_NB: vaddr = KW'(ard_q) < cnt_k ? VW'(ard_q) : v_q;
			S_NB_CHK: aaddr = rd_last[AW-1:0];
			S_SCAN: begin
				aaddr = j_q[AW-1:0];
				awe   = hit;
			end
			S_NB_WB: begin
				vwe    = 1'b1;
				vwaddr = nb_q;
				vwdata = {1'b0, noff_q, ndeg_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (vwe) vmem[vwaddr] <= vwdata;
		vrd_q <= vmem[vaddr];
	end

	always_ff @(posedge clk) begin
		if (awe) amem[awaddr] <= awdata;
		ard_q <= amem[aaddr];
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				v_q    <= vidx;
				f_q    <= '0;
				best_q <= '0;
				bdeg_q <= '0;
			end
			S_FIND: begin
				if (f_more) f_q <= f_q + KW'(1);
				if (fv_s1 && !rd_del && rd_deg > bdeg_q) begin
					bdeg_q <= rd_deg;
					best_q <= fa_s1;
				end
			end
			S_DEL_CHK: begin
				voff_q <= rd_off;
				vdeg_q <= rd_deg;
				i_q    <= CW'(rd_off);
			end
			S_WALK_NB: begin
				nb_q <= VW'(ard_q);
				if (nb_bad) i_q <= i_q + CW'(1);
			end
			S_NB_CHK: begin
				noff_q <= rd_off;
				ndeg_q <= rd_deg;
				j_q    <= CW'(rd_off);
				last_q <= rd_end;
				if (rd_del || rd_end_bad || rd_deg == '0) i_q <= i_q + CW'(1);
			end
			S_NB_LAST: lastval_q <= ard_q;
			S_SCAN: begin
				if (j_more) begin
					j_q   <= j_q + CW'(1);
					sa_s1 <= j_q[AW-1:0];
				end
				if (hit && ndeg_q != '0) ndeg_q <= ndeg_q - DEG_W'(1);
			end
			S_NB_WB: begin
				if (nb_q == v_q) vdeg_q <= ndeg_q;
				i_q <= i_q + CW'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		fa_s1 <= f_q[VW-1:0];
	end

	// state machine and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			vcount_q     <= VCOUNT_RESET;
			bad_q        <= 1'b0;
			sc_s1        <= 1'b0;
			fv_s1        <= 1'b0;
			out_valid_q  <= 1'b0;
			max_vertex_q <= '0;
			status_q     <= ST_OK;
		end else begin
			if (cfg_valid && cfg_ready) vcount_q <= cfg_data;
			if (take) out_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + VW'(1);
					if (clr_q == VW'(MAX_VERTICES - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					fv_s1 <= 1'b0;
					bad_q <= 1'b0;
					if (acc) begin
						max_vertex_q <= '0;
						case (command)
							CMD_LOAD_VERTEX: begin
								out_valid_q <= 1'b1;
								status_q    <= vok ? ST_OK : ST_BAD;
							end
							CMD_LOAD_ADJ: begin
								out_valid_q <= 1'b1;
								status_q    <= aok ? ST_OK : ST_BAD;
							end
							CMD_DELETE: begin
								if (vok) begin
									state_q <= S_DEL_CHK;
								end else begin
									out_valid_q <= 1'b1;
									status_q    <= ST_BAD;
								end
							end
							default: state_q <= S_FIND;
						endcase
					end
				end
				S_FIND: begin
					// issue one read a cycle, compare the word from the cycle before
					fv_s1 <= f_more;
					if (!f_more && !fv_s1) begin
						out_valid_q  <= 1'b1;
						max_vertex_q <= VTX_W'(best_q);
						status_q     <= ST_OK;
						state_q      <= S_IDLE;
					end
				end
				S_DEL_CHK: begin
					if (rd_del || rd_end_bad) begin
						// already deleted: no change; list past the store: reject
						out_valid_q <= 1'b1;
						status_q    <= rd_del ? ST_OK : ST_BAD;
						state_q     <= S_IDLE;
					end else begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (walk_more) begin
						state_q <= S_WALK_NB;
					end else begin
						out_valid_q <= 1'b1;
						status_q    <= bad_q ? ST_BAD : ST_OK;
						state_q     <= S_IDLE;
					end
				end
				S_WALK_NB: begin
					if (nb_bad) begin
						bad_q   <= 1'b1;
						state_q <= S_WALK;
					end else begin
						state_q <= S_NB_CHK;
					end
				end
				S_NB_CHK: begin
					if (rd_del || rd_deg == '0) begin
						state_q <= S_WALK;
					end else if (rd_end_bad) begin
						bad_q   <= 1'b1;
						state_q <= S_WALK;
					end else begin
						state_q <= S_NB_LAST;
					end
				end
				S_NB_LAST: begin
					sc_s1   <= 1'b0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					// replace each match by the entry at the original list end
					sc_s1 <= j_more;
					if (!j_more && !sc_s1) state_q <= S_NB_WB;
				end
				S_NB_WB: state_q <= S_WALK;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== tb/sv/max_degree_tracker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the CSR vertex deletion / max degree unit: keeps its own copy
// of the graph store and predicts max_vertex and status. Depends on csrvd_pkg.
class max_degree_tracker;
	typedef struct packed {
		logic [csrvd_pkg::VTX_W-1:0] max_vertex;
		logic                        status;
	} graph_result_t;

	int unsigned   vcount;
	int unsigned   offset_tab[1024];
	int unsigned   degree_tab[1024];
	bit            gone_tab[1024];
	int unsigned   adj_tab[8192];
	graph_result_t pending_q[$];
	int            errors;

	function void clear_state();
		vcount = 1024;
		errors = 0;
		foreach (offset_tab[i]) begin
			offset_tab[i] = 0;
			degree_tab[i] = 0;
			gone_tab[i]   = 0;
		end
		foreach (adj_tab[i])
			adj_tab[i] = 0;
	endfunction

	function void set_count(logic [csrvd_pkg::CFG_W-1:0] value);
		vcount = value;
	endfunction

	function int unsigned live_count();
		return (vcount > 1024) ? 1024 : vcount;
	endfunction

	function logic remove_vertex(int unsigned v);
		int unsigned cnt;
		int unsigned nb;
		int unsigned last;
		logic bad;
		cnt = live_count();
		bad = 0;
		if (gone_tab[v])
			return 0;
		if (offset_tab[v] + degree_tab[v] > 8192)
			return 1;
		// the walk end follows the current degree, so a self loop shortens it
		for (int unsigned i = offset_tab[v]; i < offset_tab[v] + degree_tab[v]; i++) begin
			nb = adj_tab[i];
			if (nb >= cnt) begin
				bad = 1;
				continue;
			end
			if (gone_tab[nb])
				continue;
			last = offset_tab[nb] + degree_tab[nb];
			if (last > 8192) begin
				bad = 1;
				continue;
			end
			for (int unsigned j = offset_tab[nb]; j < last; j++) begin
				if (adj_tab[j] == v) begin
					adj_tab[j] = adj_tab[last-1];
					if (degree_tab[nb] > 0)
						degree_tab[nb]--;
				end
			end
		end
		gone_tab[v] = 1;
		return bad;
	endfunction

	function int unsigned find_max();
		int unsigned best;
		int unsigned best_deg;
		best = 0;
		best_deg = 0;
		for (int unsigned i = 0; i < live_count(); i++) begin
			if (!gone_tab[i] && degree_tab[i] > best_deg) begin
				best_deg = degree_tab[i];
				best = i;
			end
		end
		return best;
	endfunction

	function void note_command(csrvd_pkg::cmd_t cmd, int unsigned v, int unsigned off,
			int unsigned deg, int unsigned ai, int unsigned nb);
		graph_result_t r;
		r.max_vertex = 0;
		r.status = csrvd_pkg::ST_OK;
		case (cmd)
			csrvd_pkg::CMD_LOAD_VERTEX: begin
				if (v < live_count()) begin
					offset_tab[v] = off;
					degree_tab[v] = deg;
					gone_tab[v] = 0;
				end else
					r.status = csrvd_pkg::ST_BAD;
			end
			csrvd_pkg::CMD_LOAD_ADJ: begin
				if (ai < 8192)
					adj_tab[ai] = nb;
				else
					r.status = csrvd_pkg::ST_BAD;
			end
			csrvd_pkg::CMD_DELETE: begin
				if (v < live_count())
					r.status = remove_vertex(v);
				else
					r.status = csrvd_pkg::ST_BAD;
			end
			default: begin
				r.max_vertex = find_max();
			end
		endcase
		pending_q.push_back(r);
	endfunction

	task report(string msg);
		$display("mismatch at %0t: %s", $time, msg);
		errors++;
	endtask

	task check_result(logic [csrvd_pkg::VTX_W-1:0] mv, logic st);
		graph_result_t e;
		if (pending_q.size() == 0) begin
			report($sformatf("result %0d/%0d with nothing outstanding", mv, st));
		end else begin
			e = pending_q.pop_front();
			if (mv !== e.max_vertex)
				report($sformatf("max_vertex %0d, expected %0d", mv, e.max_vertex));
			if (st !== e.status)
				report($sformatf("status %0d, expected %0d", st, e.status));
		end
	endtask
endclass

// ===== tb/sv/csr_vertex_delete_max_degree_unit_tb.sv =====
`timescale 1ns / 100ps
// Top-level testbench for csr_vertex_delete_max_degree_unit: builds random graphs,
// deletes and searches them under random flow control. Depends on csrvd_pkg and
// max_degree_tracker.
module csr_vertex_delete_max_degree_unit_tb;
	import csrvd_pkg::*;

	logic             clk;
	logic             arst_n;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data;
	logic             in_valid;
	logic             in_stall;
	logic [CMD_W-1:0] command;
	logic [VTX_W-1:0] vertex;
	logic [OFF_W-1:0] start_offset;
	logic [DEG_W-1:0] initial_degree;
	logic [OFF_W-1:0] adj_index;
	logic [VTX_W-1:0] neighbor;
	logic             out_valid;
	logic             out_stall;
	logic [VTX_W-1:0] max_vertex;
	logic             status;

	csr_vertex_delete_max_degree_unit i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.vertex         (vertex),
		.start_offset   (start_offset),
		.initial_degree (initial_degree),
		.adj_index      (adj_index),
		.neighbor       (neighbor),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.max_vertex     (max_vertex),
		.status         (status)
	);

	max_degree_tracker tracker = new();

	// Stimulus-side bookkeeping: which entries hold known values, so that
	// find and delete never read a store entry that was never written.
	bit          vtx_loaded[1024];
	bit          adj_written[8192];
	int unsigned gen_count;
	int          burst_left;
	bit          hold_req;

	// Graph under construction: neighbor lists of the active vertices.
	int unsigned nbr_lists[64][$];
	int unsigned bld_off[64];
	int unsigned bld_deg[64];

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Check every result transaction at the edge that moves it.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_result(max_vertex, status);
	end

	// Receiver: stall in patterns of its own; once, hold off for a long stretch
	// so the block backs up and stalls its input.
	initial begin : receiver
		int hold_left;
		int mode;
		int mode_left;
		bit hold_done;
		hold_left = 0;
		mode = 0;
		mode_left = 0;
		hold_done = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_left = 400;
				hold_done = 1;
			end
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 2);
					mode_left = $urandom_range(8, 60);
				end
				mode_left--;
				case (mode)
					0: out_stall = 1'b0;
					1: out_stall = ($urandom_range(0, 2) == 0);
					default: out_stall = !out_stall;
				endcase
			end
		end
	end

	function int unsigned live_gen_count();
		return (gen_count > 1024) ? 1024 : gen_count;
	endfunction

	function bit all_loaded();
		for (int unsigned i = 0; i < live_gen_count(); i++)
			if (!vtx_loaded[i])
				return 0;
		return 1;
	endfunction

	function bit range_written(int unsigned off, int unsigned deg);
		if (off + deg > 8192)
			return 1;
		for (int unsigned i = off; i < off + deg; i++)
			if (!adj_written[i])
				return 0;
		return 1;
	endfunction

	// Drive one command transaction; called and returning at a falling edge.
	task send_cmd(cmd_t cmd, int unsigned v, int unsigned off, int unsigned deg,
			int unsigned ai, int unsigned nb);
		if (burst_left == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
			                                         : $urandom_range(1, 12);
		end
		burst_left--;
		command = cmd;
		vertex = VTX_W'(v);
		start_offset = OFF_W'(off);
		initial_degree = DEG_W'(deg);
		adj_index = OFF_W'(ai);
		neighbor = VTX_W'(nb);
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		tracker.note_command(cmd, v, off, deg, ai, nb);
		if (cmd == CMD_LOAD_VERTEX && v < live_gen_count())
			vtx_loaded[v] = 1;
		if (cmd == CMD_LOAD_ADJ)
			adj_written[ai] = 1;
		@(negedge clk);
	endtask

	// Drop valid and wait until every result is back, so the block is idle.
	task drain();
		in_valid = 1'b0;
		while (tracker.pending_q.size() > 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task write_vertex_count(int unsigned value);
		drain();
		cfg_data = CFG_W'(value);
		cfg_valid = 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		tracker.set_count(CFG_W'(value));
		gen_count = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Build a random graph on vertices below k; the rest of the live range
	// gets empty lists. Include a self loop, an out-of-range neighbor and a
	// vertex whose list runs past the end of the store.
	task build_graph(int unsigned k);
		int unsigned a;
		int unsigned b;
		int unsigned cursor;
		int unsigned cnt;
		cnt = live_gen_count();
		for (int i = 0; i < 64; i++)
			nbr_lists[i].delete();
		repeat (k * 2) begin
			a = $urandom_range(0, k - 1);
			b = $urandom_range(0, k - 1);
			nbr_lists[a].push_back(b);
			if (a != b)
				nbr_lists[b].push_back(a);
		end
		nbr_lists[0].push_back(0);
		if (cnt < 1024)
			nbr_lists[0].push_back($urandom_range(cnt, 1023));
		cursor = $urandom_range(0, 4000);
		for (int unsigned v = 0; v < k; v++) begin
			if (k >= 3 && v == k - 1) begin
				bld_off[v] = 8191;
				bld_deg[v] = nbr_lists[v].size() + 2;
				send_cmd(CMD_LOAD_ADJ, $urandom, $urandom, $urandom, 8191,
					(nbr_lists[v].size() > 0) ? nbr_lists[v][0] : 0);
			end else begin
				bld_off[v] = cursor;
				bld_deg[v] = nbr_lists[v].size();
				foreach (nbr_lists[v][i])
					send_cmd(CMD_LOAD_ADJ, $urandom, $urandom, $urandom, cursor + i,
						nbr_lists[v][i]);
				cursor += nbr_lists[v].size();
			end
		end
		for (int unsigned v = 0; v < k; v++)
			send_cmd(CMD_LOAD_VERTEX, v, bld_off[v], bld_deg[v], $urandom, $urandom);
		for (int unsigned v = k; v < cnt; v++)
			send_cmd(CMD_LOAD_VERTEX, v, $urandom_range(0, 8191), 0, $urandom, $urandom);
	endtask

	// Mostly deletes, searches and reloads on the built graph, with some noise.
	task random_ops(int unsigned k, int n);
		int unsigned pick;
		int unsigned v;
		int unsigned off;
		int unsigned deg;
		int unsigned ai;
		cmd_t cmd;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, live_gen_count() - 1)
				                               : $urandom_range(0, k - 1);
				send_cmd(CMD_DELETE, v, $urandom, $urandom, $urandom, $urandom);
			end else if (pick < 60) begin
				send_cmd(CMD_FIND, $urandom, $urandom, $urandom, $urandom, $urandom);
			end else if (pick < 75) begin
				v = $urandom_range(0, k - 1);
				send_cmd(CMD_LOAD_VERTEX, v, bld_off[v], bld_deg[v], $urandom, $urandom);
			end else if (pick < 85 && bld_deg[0] > 0) begin
				// rewrite an entry of a live list with another active vertex
				ai = bld_off[0] + $urandom_range(0, bld_deg[0] - 1);
				send_cmd(CMD_LOAD_ADJ, $urandom, $urandom, $urandom, ai,
					$urandom_range(0, k - 1));
			end else begin
				cmd = cmd_t'($urandom_range(0, 3));
				v = $urandom_range(0, 1023);
				off = $urandom_range(0, 8191);
				deg = $urandom_range(0, 1023);
				if (cmd == CMD_LOAD_VERTEX && v < live_gen_count() && !range_written(off, deg))
					deg = 0;
				if ((cmd == CMD_DELETE || cmd == CMD_FIND) && !all_loaded())
					cmd = CMD_LOAD_ADJ;
				send_cmd(cmd, v, off, deg, $urandom_range(0, 8191), $urandom_range(0, 1023));
			end
		end
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		command = CMD_LOAD_VERTEX;
		vertex = '0;
		start_offset = '0;
		initial_degree = '0;
		adj_index = '0;
		neighbor = '0;
		hold_req = 0;
		burst_left = 0;
		gen_count = 1024;
		tracker.clear_state();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Directed: store extremes, then a single-vertex graph with a self loop,
		// repeated delete, out-of-range vertex, list past the store end and a
		// neighbor above the count.
		send_cmd(CMD_LOAD_ADJ, 0, 0, 0, 0, 1023);
		send_cmd(CMD_LOAD_ADJ, 1023, 8191, 1023, 8191, 0);
		write_vertex_count(1);
		send_cmd(CMD_LOAD_VERTEX, 0, 8191, 1, 0, 0);
		send_cmd(CMD_FIND, 0, 0, 0, 0, 0);
		send_cmd(CMD_DELETE, 0, 0, 0, 0, 0);
		send_cmd(CMD_DELETE, 0, 0, 0, 0, 0);
		send_cmd(CMD_FIND, 0, 0, 0, 0, 0);
		send_cmd(CMD_LOAD_VERTEX, 1, 0, 0, 0, 0);
		send_cmd(CMD_DELETE, 1023, 0, 0, 0, 0);
		send_cmd(CMD_LOAD_VERTEX, 0, 8191, 2, 0, 0);
		send_cmd(CMD_DELETE, 0, 0, 0, 0, 0);
		send_cmd(CMD_FIND, 0, 0, 0, 0, 0);
		send_cmd(CMD_LOAD_VERTEX, 0, 0, 1, 0, 0);
		send_cmd(CMD_FIND, 0, 0, 0, 0, 0);
		send_cmd(CMD_DELETE, 0, 0, 0, 0, 0);
		send_cmd(CMD_FIND, 0, 0, 0, 0, 0);

		write_vertex_count(8);
		build_graph(8);
		random_ops(8, 60);

		write_vertex_count(40);
		build_graph(24);
		hold_req = 1;
		random_ops(24, 180);

		// Count above the vertex store: the top vertex is in range.
		write_vertex_count(2047);
		send_cmd(CMD_LOAD_VERTEX, 1023, 0, 0, 0, 0);
		send_cmd(CMD_DELETE, 1023, 0, 0, 0, 0);
		send_cmd(CMD_DELETE, 1023, 0, 0, 0, 0);
		send_cmd(CMD_LOAD_VERTEX, 1023, 100, 0, 0, 0);
		send_cmd(CMD_DELETE, 1023, 0, 0, 0, 0);

		drain();
		repeat (30) @(negedge clk);
		if (tracker.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end
endmodule
